// ----- src/sexpr_token_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the S-expression token classifier
// Same-cycle and next-cycle implication checks, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SEXPR_TOKEN_CLASSIFIER_ASSERT_SVH
`define SEXPR_TOKEN_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define STC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sexpr_token_classifier: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sexpr_token_classifier: next-cycle check failed");

`else

`define STC_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define STC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/stc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and character-class functions of the token classifier.
// ----------------------------------------------------------------------------
package stc_pkg;

   // Default configuration.
   localparam int STC_MAX_WORD_COUNT = 255;
   localparam int STC_QUEUE_DEPTH    = 4;

   // Token kinds.
   localparam logic [2:0] KIND_EOF    = 3'd0;
   localparam logic [2:0] KIND_DELIM  = 3'd1;
   localparam logic [2:0] KIND_NUMBER = 3'd2;
   localparam logic [2:0] KIND_DEF    = 3'd3;
   localparam logic [2:0] KIND_EXTERN = 3'd4;
   localparam logic [2:0] KIND_IF     = 3'd5;
   localparam logic [2:0] KIND_SYMBOL = 3'd6;
   localparam logic [2:0] KIND_IDENT  = 3'd7;

   // Numeric recognizer states.
   localparam logic [2:0] NS_PREFIX = 3'd0;
   localparam logic [2:0] NS_INT    = 3'd2;
   localparam logic [2:0] NS_FRAC   = 3'd3;
   localparam logic [2:0] NS_EXP    = 3'd4;
   localparam logic [2:0] NS_FAIL   = 3'd7;

   // Keyword slots in the hit vector.
   localparam logic [1:0] KW_DEF    = 2'd0;
   localparam logic [1:0] KW_EXTERN = 2'd1;
   localparam logic [1:0] KW_IF     = 2'd2;

   // One queued command: an optional word token and an optional tail token.
   typedef struct packed {
      logic       word_valid;
      logic [2:0] word_kind;
      logic [7:0] word_char;
      logic [7:0] word_len;
      logic       word_sat;
      logic       tail_valid;
      logic [2:0] tail_kind;
      logic [7:0] tail_char;
   } stc_cmd_type;

   // Queue status seen by the front end.
   typedef struct packed {
      logic full;
      logic empty;
   } stc_qstat_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == 8'h28) || (c == 8'h29) || (c == 8'h27) || (c == 8'h22) ||
             (c == 8'h60) || (c == 8'h3B) || (c == 8'h7C) || (c == 8'h5B) ||
             (c == 8'h5D) || (c == 8'h7B) || (c == 8'h7D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
             ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   // Numeric recognizer step; letters are folded to lower case.
   function automatic logic [2:0] next_num_state(input logic [2:0] s,
                                                 input logic [7:0] c);
      logic [7:0] lc;
      logic [2:0] ns;
      lc = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
      if (s == NS_FAIL) begin
         ns = NS_FAIL;
      end else begin
         case (lc)
            8'h23, 8'h62, 8'h6F, 8'h78, 8'h69: begin
               ns = (s == NS_PREFIX) ? s : NS_FAIL;
            end
            8'h73, 8'h66, 8'h6C: begin
               ns = ((s == NS_INT) || (s == NS_FRAC)) ? NS_EXP : NS_FAIL;
            end
            8'h64, 8'h65: begin
               if (s == NS_PREFIX) begin
                  ns = s;
               end else begin
                  ns = ((s == NS_INT) || (s == NS_FRAC)) ? NS_EXP : NS_FAIL;
               end
            end
            8'h2E: begin
               ns = ((s == NS_PREFIX) || (s == NS_INT)) ? NS_FRAC : NS_FAIL;
            end
            default: begin
               if (is_digit(lc)) begin
                  ns = (s == NS_PREFIX) ? NS_INT : s;
               end else begin
                  ns = NS_FAIL;
               end
            end
         endcase
      end
      return ns;
   endfunction

   // Keyword lengths.
   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] n;
      case (k)
         KW_DEF:    n = 3'd3;
         KW_EXTERN: n = 3'd6;
         KW_IF:     n = 3'd2;
         default:   n = 3'd0;
      endcase
      return n;
   endfunction

   // Keyword text, one byte at a position.
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      case (k)
         KW_DEF: begin
            case (pos)
               3'd0:    ch = 8'h64;
               3'd1:    ch = 8'h65;
               3'd2:    ch = 8'h66;
               default: ch = 8'h00;
            endcase
         end
         KW_EXTERN: begin
            case (pos)
               3'd0:    ch = 8'h65;
               3'd1:    ch = 8'h78;
               3'd2:    ch = 8'h74;
               3'd3:    ch = 8'h65;
               3'd4:    ch = 8'h72;
               3'd5:    ch = 8'h6E;
               default: ch = 8'h00;
            endcase
         end
         KW_IF: begin
            case (pos)
               3'd0:    ch = 8'h69;
               3'd1:    ch = 8'h66;
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- src/stc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token classifier channels
// Valid/ready channels for the character stream and the token stream.
// ----------------------------------------------------------------------------

// Character stream: one byte or an end-of-input mark per transaction.
interface stc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_input;

   modport source (output valid, output in_char, output end_of_input, input ready);
   modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

// Token stream: one classified token per transaction.
interface stc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] token_kind;
   logic [7:0] token_char;
   logic [7:0] token_length;
   logic       length_saturated;
   logic       last_of_run;

   modport source (output valid, output token_kind, output token_char,
                   output token_length, output length_saturated,
                   output last_of_run, input ready);
   modport sink   (input valid, input token_kind, input token_char,
                   input token_length, input length_saturated,
                   input last_of_run, output ready);
endinterface

// ----- src/stc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_front
// Accepts characters, tracks the open word and queues token commands.
// ----------------------------------------------------------------------------
module stc_front #(
   parameter int MAX_WORD_COUNT = stc_pkg::STC_MAX_WORD_COUNT
) (
   input  logic                  clock,
   input  logic                  reset,
   stc_req_if.sink               req_bus,
   input  stc_pkg::stc_qstat_type q_stat,
   output logic                  cmd_push,
   output stc_pkg::stc_cmd_type  cmd_data
);
   import stc_pkg::*;

   localparam int LEN_W = $clog2(MAX_WORD_COUNT + 1);
   localparam int EXT_W = (LEN_W > 8) ? LEN_W : 9;

   logic             inside_ff, inside_in;
   logic [2:0]       num_state_ff, num_state_in;
   logic [2:0]       kw_hits_ff, kw_hits_in;
   logic [7:0]       first_char_ff, first_char_in;
   logic [LEN_W-1:0] word_len_ff, word_len_in;
   logic             word_ovf_ff, word_ovf_in;

   logic             accept;
   logic [7:0]       c;
   logic [EXT_W-1:0] len_ext;
   logic [7:0]       len_clamped;
   logic [2:0]       word_kind;
   logic             kw_ok;

   assign req_bus.ready = !q_stat.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign c             = req_bus.in_char;

   // Word length reported on the token, clamped to eight bits.
   assign len_ext     = EXT_W'(word_len_ff);
   assign len_clamped = (len_ext > EXT_W'(255)) ? 8'hFF : len_ext[7:0];

   // Classify the open word: number, keyword, lone symbol, else identifier.
   always_comb begin
      if ((num_state_ff != NS_PREFIX) && (num_state_ff != NS_FAIL)) begin
         word_kind = KIND_NUMBER;
      end else if (kw_hits_ff[KW_DEF] && (len_ext == EXT_W'(kw_len(KW_DEF)))) begin
         word_kind = KIND_DEF;
      end else if (kw_hits_ff[KW_EXTERN] &&
                   (len_ext == EXT_W'(kw_len(KW_EXTERN)))) begin
         word_kind = KIND_EXTERN;
      end else if (kw_hits_ff[KW_IF] && (len_ext == EXT_W'(kw_len(KW_IF)))) begin
         word_kind = KIND_IF;
      end else if ((len_ext == EXT_W'(1)) && !is_alnum(first_char_ff)) begin
         word_kind = KIND_SYMBOL;
      end else begin
         word_kind = KIND_IDENT;
      end
   end

   // Next word state and the command for the queue.
   always_comb begin
      inside_in     = inside_ff;
      num_state_in  = num_state_ff;
      kw_hits_in    = kw_hits_ff;
      first_char_in = first_char_ff;
      word_len_in   = word_len_ff;
      word_ovf_in   = word_ovf_ff;
      kw_ok         = 1'b0;
      cmd_push      = 1'b0;
      cmd_data      = '0;

      cmd_data.word_valid = inside_ff;
      cmd_data.word_kind  = word_kind;
      cmd_data.word_char  = first_char_ff;
      cmd_data.word_len   = len_clamped;
      cmd_data.word_sat   = word_ovf_ff;

      if (accept) begin
         if (req_bus.end_of_input || is_space(c) || is_delim(c)) begin
            // Closing the word: the queue gets the word and any tail token.
            if (req_bus.end_of_input) begin
               cmd_data.tail_valid = 1'b1;
               cmd_data.tail_kind  = KIND_EOF;
               cmd_data.tail_char  = 8'h00;
               cmd_push            = 1'b1;
            end else if (is_delim(c)) begin
               cmd_data.tail_valid = 1'b1;
               cmd_data.tail_kind  = KIND_DELIM;
               cmd_data.tail_char  = c;
               cmd_push            = 1'b1;
            end else begin
               cmd_push = inside_ff;
            end
            inside_in     = 1'b0;
            num_state_in  = NS_PREFIX;
            kw_hits_in    = 3'b111;
            first_char_in = 8'h00;
            word_len_in   = '0;
            word_ovf_in   = 1'b0;
         end else begin
            // Ordinary byte joins the word.
            if (!inside_ff) begin
               inside_in     = 1'b1;
               first_char_in = c;
            end
            num_state_in = next_num_state(num_state_ff, c);
            for (int k = 0; k < 3; k++) begin
               kw_ok = (len_ext < EXT_W'(8)) &&
                       (len_ext[2:0] < kw_len(2'(k))) &&
                       (kw_char(2'(k), len_ext[2:0]) == c);
               if (!kw_ok) begin
                  kw_hits_in[k] = 1'b0;
               end
            end
            if (word_len_ff < LEN_W'(MAX_WORD_COUNT)) begin
               word_len_in = word_len_ff + LEN_W'(1);
            end else begin
               word_ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff     <= 1'b0;
         num_state_ff  <= NS_PREFIX;
         kw_hits_ff    <= 3'b111;
         first_char_ff <= 8'h00;
         word_len_ff   <= '0;
         word_ovf_ff   <= 1'b0;
      end else begin
         inside_ff     <= inside_in;
         num_state_ff  <= num_state_in;
         kw_hits_ff    <= kw_hits_in;
         first_char_ff <= first_char_in;
         word_len_ff   <= word_len_in;
         word_ovf_ff   <= word_ovf_in;
      end
   end

endmodule

// ----- src/stc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_queue
// Short first-in first-out queue of token commands between front and back.
// ----------------------------------------------------------------------------
`include "sexpr_token_classifier_assert.svh"

module stc_queue #(
   parameter int DEPTH = stc_pkg::STC_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  stc_pkg::stc_cmd_type   push_data,
   input  logic                   pop,
   output stc_pkg::stc_cmd_type   head_data,
   output stc_pkg::stc_qstat_type stat
);
   import stc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   stc_cmd_type      entries [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head_data  = entries[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   // Occupancy never exceeds the depth, and the ends never over- or underrun.
   `STC_ASSERT_SAME(a_queue_no_overflow, clock, reset, push, !stat.full || pop)
   `STC_ASSERT_SAME(a_queue_no_underflow, clock, reset, pop, !stat.empty)
   `STC_ASSERT_SAME(a_queue_count_bound, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH))

endmodule

// ----- src/stc_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stc_emit
// Takes queued commands; sends word and tail tokens one per cycle when ready.
// ----------------------------------------------------------------------------
`include "sexpr_token_classifier_assert.svh"

module stc_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  stc_pkg::stc_cmd_type   head_data,
   input  stc_pkg::stc_qstat_type q_stat,
   output logic                   cmd_pop,
   stc_rsp_if.source              rsp_bus
);
   import stc_pkg::*;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic [7:0] len_ff, len_in;
   logic       sat_ff, sat_in;
   logic       last_ff, last_in;

   // Tail token held back while its word token is on the output.
   logic       tail_pend_ff, tail_pend_in;
   logic [2:0] tail_kind_ff, tail_kind_in;
   logic [7:0] tail_char_ff, tail_char_in;

   logic       load;

   assign load = !rsp_valid_ff || rsp_bus.ready;

   // Select the next token: held tail first, then the head of the queue.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      len_in       = len_ff;
      sat_in       = sat_ff;
      last_in      = last_ff;
      tail_pend_in = tail_pend_ff;
      tail_kind_in = tail_kind_ff;
      tail_char_in = tail_char_ff;
      cmd_pop      = 1'b0;

      if (load) begin
         rsp_valid_in = 1'b0;
         if (tail_pend_ff) begin
            rsp_valid_in = 1'b1;
            kind_in      = tail_kind_ff;
            char_in      = tail_char_ff;
            len_in       = 8'h00;
            sat_in       = 1'b0;
            last_in      = 1'b1;
            tail_pend_in = 1'b0;
         end else if (!q_stat.empty) begin
            cmd_pop      = 1'b1;
            rsp_valid_in = 1'b1;
            if (head_data.word_valid) begin
               kind_in      = head_data.word_kind;
               char_in      = head_data.word_char;
               len_in       = head_data.word_len;
               sat_in       = head_data.word_sat;
               last_in      = !head_data.tail_valid;
               tail_pend_in = head_data.tail_valid;
               tail_kind_in = head_data.tail_kind;
               tail_char_in = head_data.tail_char;
            end else begin
               kind_in = head_data.tail_kind;
               char_in = head_data.tail_char;
               len_in  = 8'h00;
               sat_in  = 1'b0;
               last_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tail_pend_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tail_pend_ff <= tail_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      len_ff       <= len_in;
      sat_ff       <= sat_in;
      last_ff      <= last_in;
      tail_kind_ff <= tail_kind_in;
      tail_char_ff <= tail_char_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.token_kind       = kind_ff;
   assign rsp_bus.token_char       = char_ff;
   assign rsp_bus.token_length     = len_ff;
   assign rsp_bus.length_saturated = sat_ff;
   assign rsp_bus.last_of_run      = last_ff;

   // A word token that is not last always has its tail held behind it.
   `STC_ASSERT_SAME(a_emit_word_has_tail, clock, reset,
                    rsp_valid_ff && !last_ff, tail_pend_ff)
   `STC_ASSERT_SAME(a_emit_tail_behind_word, clock, reset,
                    tail_pend_ff, rsp_valid_ff && !last_ff)
   `STC_ASSERT_SAME(a_emit_no_pop_with_tail, clock, reset, cmd_pop, !tail_pend_ff)

endmodule

// ----- src/sexpr_token_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_token_classifier
// Lexer for S-expression text: one byte in, classified tokens out.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while the command queue has room. An
// input that only extends a word, or that is whitespace outside a word, gives
// no token; a delimiter, closing whitespace or end of input gives one token, or
// two when it also closes a word (the word token first). The output register
// sends one token per cycle while the receiver is ready; a four-entry command
// queue between the front end and the emitter absorbs inputs with two tokens,
// and the character port stalls only when the queue fills. Words are counted
// up to MAX_WORD_COUNT bytes with a saturation flag.
module sexpr_token_classifier #(
   parameter int MAX_WORD_COUNT = stc_pkg::STC_MAX_WORD_COUNT,
   parameter int QUEUE_DEPTH    = stc_pkg::STC_QUEUE_DEPTH
) (
   input logic       clock,
   input logic       reset,
   stc_req_if.sink   req_bus,
   stc_rsp_if.source rsp_bus
);
   import stc_pkg::*;

   logic          cmd_push;
   logic          cmd_pop;
   stc_cmd_type   cmd_data;
   stc_cmd_type   head_data;
   stc_qstat_type q_stat;

   // Front end: word tracking and classification.
   stc_front #(
      .MAX_WORD_COUNT (MAX_WORD_COUNT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_stat   (q_stat),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   // Command queue.
   stc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head_data (head_data),
      .stat      (q_stat)
   );

   // Back end: token output.
   stc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_stat    (q_stat),
      .cmd_pop   (cmd_pop),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the S-expression token classifier. A stimulus
// process queues a byte stream: a short directed opening, then random
// keywords, numbers, identifiers, symbols, long words and noise, cut up by
// whitespace, delimiters and end-of-input marks. A clocked driver sends the
// bytes and runs a lexer model on each accepted transaction. A clocked
// monitor compares every token against the oldest predicted one. Both sides
// idle at random, except in one stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module tb_top;
   import stc_pkg::*;

   localparam int WORD_LIMIT   = STC_MAX_WORD_COUNT;
   localparam int RANDOM_BYTES = 1150;
   localparam int IDLE_PCT     = 24;
   localparam int CALM_FIRST   = 600;
   localparam int CALM_LAST    = 1000;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS  = 60;

   // One byte of the stream, or an end-of-input mark.
   typedef struct packed {
      logic [7:0] ch;
      logic       eoi;
   } lex_in_type;

   // One token as the block reports it.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [7:0] len;
      logic       sat;
      logic       last;
   } token_type;

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   err_count   = 0;

   lex_in_type char_q[$];
   token_type  token_q[$];

   // Lexer state of the model.
   logic       in_word;
   logic [2:0] num_state;
   logic [2:0] kw_hits;
   logic [7:0] first_ch;
   logic [7:0] word_len;
   logic       word_ovf;

   string kw_text[3] = '{"def", "extern", "if"};

   stc_req_if req_bus ();
   stc_rsp_if rsp_bus ();

   sexpr_token_classifier u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Clock generation.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Character classes of the lexer.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_delimiter(input logic [7:0] c);
      string d;
      logic  hit;
      d   = "()'\"`;|[]{}";
      hit = 1'b0;
      for (int i = 0; i < d.len(); i++) begin
         if (c == d[i]) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic is_word_alnum(input logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
             ((c >= "A") && (c <= "Z"));
   endfunction

   // Numeric recognizer: letters fold to lower case before the test.
   function automatic logic [2:0] num_advance(input logic [2:0] s, input logic [7:0] c);
      logic [7:0] lc;
      logic [2:0] r;
      lc = ((c >= "A") && (c <= "Z")) ? c + 8'd32 : c;
      if (s == NS_FAIL) begin
         r = NS_FAIL;
      end else if ((lc == "#") || (lc == "b") || (lc == "o") || (lc == "x") ||
                   (lc == "i")) begin
         r = (s == NS_PREFIX) ? NS_PREFIX : NS_FAIL;
      end else if ((lc == "s") || (lc == "f") || (lc == "l")) begin
         r = ((s == NS_INT) || (s == NS_FRAC)) ? NS_EXP : NS_FAIL;
      end else if ((lc == "d") || (lc == "e")) begin
         if (s == NS_PREFIX) begin
            r = NS_PREFIX;
         end else begin
            r = ((s == NS_INT) || (s == NS_FRAC)) ? NS_EXP : NS_FAIL;
         end
      end else if (lc == ".") begin
         r = ((s == NS_PREFIX) || (s == NS_INT)) ? NS_FRAC : NS_FAIL;
      end else if ((lc >= "0") && (lc <= "9")) begin
         r = (s == NS_PREFIX) ? NS_INT : s;
      end else begin
         r = NS_FAIL;
      end
      return r;
   endfunction

   function automatic void clear_word();
      in_word   = 1'b0;
      num_state = NS_PREFIX;
      kw_hits   = 3'b111;
      first_ch  = 8'h00;
      word_len  = 8'h00;
      word_ovf  = 1'b0;
   endfunction

   // Classifies the gathered word and starts a fresh one.
   function automatic token_type close_word();
      token_type  t;
      logic [2:0] kind_tab[3];
      kind_tab = '{KIND_DEF, KIND_EXTERN, KIND_IF};
      t.kind   = KIND_IDENT;
      if ((num_state != NS_PREFIX) && (num_state != NS_FAIL)) begin
         t.kind = KIND_NUMBER;
      end else begin
         for (int k = 2; k >= 0; k--) begin
            if (kw_hits[k] && (word_len == kw_text[k].len())) begin
               t.kind = kind_tab[k];
            end
         end
         if ((t.kind == KIND_IDENT) && (word_len == 8'd1) && !is_word_alnum(first_ch)) begin
            t.kind = KIND_SYMBOL;
         end
      end
      t.ch   = first_ch;
      t.len  = word_len;
      t.sat  = word_ovf;
      t.last = 1'b0;
      clear_word();
      return t;
   endfunction

   // Predicts the tokens of one accepted transaction.
   function automatic void lex_byte(input logic [7:0] c, input logic eoi);
      token_type run[$];
      token_type t;
      if (eoi) begin
         if (in_word) begin
            run = {run, close_word()};
         end
         t = '{kind: KIND_EOF, ch: 8'h00, len: 8'h00, sat: 1'b0, last: 1'b0};
         run = {run, t};
         clear_word();
      end else if (is_blank(c)) begin
         if (in_word) begin
            run = {run, close_word()};
         end
      end else if (is_delimiter(c)) begin
         if (in_word) begin
            run = {run, close_word()};
         end
         t = '{kind: KIND_DELIM, ch: c, len: 8'h00, sat: 1'b0, last: 1'b0};
         run = {run, t};
      end else begin
         if (!in_word) begin
            in_word  = 1'b1;
            first_ch = c;
         end
         num_state = num_advance(num_state, c);
         for (int k = 0; k < 3; k++) begin
            if ((word_len >= kw_text[k].len()) || (kw_text[k][word_len] != c)) begin
               kw_hits[k] = 1'b0;
            end
         end
         if (word_len < WORD_LIMIT) begin
            word_len = word_len + 8'd1;
         end else begin
            word_ovf = 1'b1;
         end
      end
      if (run.size() > 0) begin
         run[run.size() - 1].last = 1'b1;
      end
      foreach (run[i]) begin
         token_q = {token_q, run[i]};
      end
   endfunction

   task automatic push_byte(input logic [7:0] c, input logic eoi);
      lex_in_type item;
      item.ch  = c;
      item.eoi = eoi;
      char_q   = {char_q, item};
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i], 1'b0);
      end
   endtask

   function automatic logic [7:0] rand_letter();
      return ($urandom_range(1) != 0) ? 8'("a") + 8'($urandom_range(25))
                                      : 8'("A") + 8'($urandom_range(25));
   endfunction

   // Stimulus: directed opening, then random words and separators.
   initial begin
      int         cat;
      int         n;
      int         long_count;
      logic [7:0] c;
      string      delims;
      string      syms;
      string      prefixes;
      string      exps;
      delims     = "()'\"`;|[]{}";
      syms       = "+-*/<>=!?#.%&~^_@$:,\\";
      prefixes   = "bodxieBODXIE";
      exps       = "esfldESFLD";
      long_count = 0;

      clear_word();
      reset                    = 1'b1;
      req_bus.valid            = 1'b0;
      req_bus.in_char          = 8'h00;
      req_bus.end_of_input     = 1'b0;
      rsp_bus.ready            = 1'b0;

      // Directed: keywords, delimiters, lone dot, a number with exponent,
      // extreme byte values and a repeated end of input.
      push_text("def(if extern;");
      push_text(". 1.5e3]");
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b1);
      push_byte(8'hA5, 1'b1);

      while (char_q.size() < RANDOM_BYTES + 26) begin
         cat = $urandom_range(99);
         if ((long_count < 2) && (char_q.size() > 300 + 500 * long_count)) begin
            // Long words: one of exactly the limit, one three bytes past it.
            n = (long_count == 0) ? WORD_LIMIT : WORD_LIMIT + 3;
            for (int i = 0; i < n; i++) begin
               push_byte((long_count == 0) ? 8'("0") + 8'($urandom_range(9))
                                           : rand_letter(), 1'b0);
            end
            long_count++;
         end else if (cat < 10) begin
            push_text(kw_text[$urandom_range(2)]);
         end else if (cat < 16) begin
            // Near misses of a keyword.
            n = $urandom_range(2);
            case ($urandom_range(3))
               0: begin
                  for (int i = 0; i < kw_text[n].len(); i++) begin
                     c = kw_text[n][i];
                     push_byte(($urandom_range(1) != 0) ? c - 8'd32 : c, 1'b0);
                  end
               end
               1: begin
                  for (int i = 0; i < kw_text[n].len() - 1; i++) begin
                     push_byte(kw_text[n][i], 1'b0);
                  end
               end
               2: begin
                  push_text(kw_text[n]);
                  push_byte(rand_letter(), 1'b0);
               end
               default: begin
                  push_byte(rand_letter(), 1'b0);
                  push_text(kw_text[n]);
               end
            endcase
         end else if (cat < 36) begin
            // Numbers: optional radix prefix, digits, fraction, exponent.
            if ($urandom_range(3) == 0) begin
               push_byte("#", 1'b0);
               push_byte(prefixes[$urandom_range(11)], 1'b0);
            end
            n = $urandom_range(4);
            for (int i = 0; i < n; i++) begin
               push_byte(8'("0") + 8'($urandom_range(9)), 1'b0);
            end
            if ($urandom_range(2) == 0) begin
               push_byte(".", 1'b0);
               n = $urandom_range(3);
               for (int i = 0; i < n; i++) begin
                  push_byte(8'("0") + 8'($urandom_range(9)), 1'b0);
               end
            end
            if ($urandom_range(2) == 0) begin
               push_byte(exps[$urandom_range(9)], 1'b0);
               if ($urandom_range(5) == 0) begin
                  push_byte(($urandom_range(1) != 0) ? "-" : ".", 1'b0);
               end
               n = $urandom_range(2);
               for (int i = 0; i < n; i++) begin
                  push_byte(8'("0") + 8'($urandom_range(9)), 1'b0);
               end
            end
         end else if (cat < 56) begin
            // Identifiers of letters, digits and punctuation.
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(5))
                  0:       push_byte(8'("0") + 8'($urandom_range(9)), 1'b0);
                  1:       push_byte(syms[$urandom_range(syms.len() - 1)], 1'b0);
                  default: push_byte(rand_letter(), 1'b0);
               endcase
            end
         end else if (cat < 64) begin
            // Lone symbols: punctuation, high bytes and control codes.
            case ($urandom_range(3))
               0:       push_byte(8'($urandom_range(128, 255)), 1'b0);
               1:       push_byte(($urandom_range(1) != 0) ? 8'($urandom_range(8))
                                  : 8'($urandom_range(14, 31)), 1'b0);
               default: push_byte(syms[$urandom_range(syms.len() - 1)], 1'b0);
            endcase
         end else if (cat < 74) begin
            // Noise over the whole byte range.
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom()), 1'b0);
            end
         end else if (cat < 80) begin
            push_byte(8'($urandom()), 1'b1);
         end

         // Separator after the word.
         cat = $urandom_range(99);
         if (cat < 50) begin
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++) begin
               push_byte(($urandom_range(1) != 0) ? 8'd32 : 8'($urandom_range(9, 13)), 1'b0);
            end
         end else if (cat < 90) begin
            push_byte(delims[$urandom_range(delims.len() - 1)], 1'b0);
         end else begin
            push_byte(8'($urandom()), 1'b1);
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Drain: all bytes sent, all tokens seen, then a short settling time.
      while ((char_q.size() != 0) || req_bus.valid) begin
         @(posedge clock);
      end
      while (token_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Driver: sends queued bytes and predicts the tokens of each transaction.
   always @(posedge clock) begin : drive_proc
      lex_in_type item;
      logic       calm;
      cycle_count <= cycle_count + 1;
      calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            lex_byte(req_bus.in_char, req_bus.end_of_input);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if ((char_q.size() != 0) && (calm || ($urandom_range(99) >= IDLE_PCT))) begin
               item = char_q.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.in_char      <= item.ch;
               req_bus.end_of_input <= item.eoi;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: applies back-pressure and checks every token transaction.
   always @(posedge clock) begin : monitor_proc
      token_type got;
      token_type want;
      logic      calm;
      calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind = rsp_bus.token_kind;
            got.ch   = rsp_bus.token_char;
            got.len  = rsp_bus.token_length;
            got.sat  = rsp_bus.length_saturated;
            got.last = rsp_bus.last_of_run;
            if (token_q.size() == 0) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display({"%0t: unexpected token: expected none, ",
                            "actual kind=%0d char=%h len=%0d sat=%b last=%b"},
                           $realtime, got.kind, got.ch, got.len, got.sat, got.last);
               end
            end else begin
               want = token_q.pop_front();
               if (got !== want) begin
                  err_count++;
                  if (err_count <= MAX_REPORTS) begin
                     $display({"%0t: token mismatch: ",
                               "expected kind=%0d char=%h len=%0d sat=%b last=%b, ",
                               "actual kind=%0d char=%h len=%0d sat=%b last=%b"},
                              $realtime, want.kind, want.ch, want.len, want.sat,
                              want.last, got.kind, got.ch, got.len, got.sat,
                              got.last);
                  end
               end
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

endmodule
